### rtl/core/sbc_pkg.sv
// shared types and codes for the sector buffer cache
`timescale 1ns / 1ps
package sbc_pkg;

  localparam int NUM_BUFFERS_DEF = 16;
  localparam int OP_W     = 2;
  localparam int DEV_W    = 8;
  localparam int SECTOR_W = 32;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 8;
  localparam int TAG_W    = DEV_W + SECTOR_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID     = 2'd0,
    ST_FILL      = 2'd1,
    ST_NOFREE    = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_GET_UPD,
    S_CNT_UPD,
    S_MRU,
    S_RESP
  } state_t;

endpackage

### rtl/core/sbc_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module sbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/sector_buffer_cache_lru.sv
// sector buffer cache tag manager with lru replacement (top level)
`timescale 1ns / 1ps
//  channel | ports                                         | direction
//  in      | in_valid in_ready in_op in_dev in_sector in_slot | request
//  out     | out_valid out_ready out_slot_out out_status      | response
//          | out_ref_count_out                             |
//
// get: one pipelined pass over the recency ram feeding the
//   tag and count rams finds both the hit and the lru victim
// pin, unpin, release: a release that frees the slot adds a pass that
//   shifts the recency ram one entry per cycle
// after reset a clearing pass fills the rams, in_ready low
// in_ready is low while an item is in work; one response waits in the output
// register while the next request is accepted
module sector_buffer_cache_lru_core #(
  parameter int NUM_BUFFERS = sbc_pkg::NUM_BUFFERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sbc_pkg::OP_W-1:0]      in_op,
  input  logic [sbc_pkg::DEV_W-1:0]     in_dev,
  input  logic [sbc_pkg::SECTOR_W-1:0]  in_sector,
  input  logic [sbc_pkg::SLOT_W-1:0]    in_slot,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sbc_pkg::SLOT_W-1:0]    out_slot_out,
  output logic [sbc_pkg::STATUS_W-1:0]  out_status,
  output logic [sbc_pkg::CNT_W-1:0]     out_ref_count_out
);
  import sbc_pkg::*;

  localparam int SW = $clog2(NUM_BUFFERS);
  localparam int CW = $clog2(NUM_BUFFERS + 2);
  localparam logic [CW-1:0] K_N    = CW'(NUM_BUFFERS);
  localparam logic [CW-1:0] K_LAST = CW'(NUM_BUFFERS + 1);
  localparam logic [SW-1:0] TOP_SLOT = SW'(NUM_BUFFERS - 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [OP_W-1:0] op_r, op_nxt;
  logic [DEV_W-1:0] dev_r, dev_nxt;
  logic [SECTOR_W-1:0] sector_r, sector_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SW-1:0] s2_slot_r, s2_slot_nxt;
  logic hit_r, hit_nxt, vic_r, vic_nxt;
  logic [SW-1:0] hit_slot_r, hit_slot_nxt, vic_slot_r, vic_slot_nxt;
  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [SW-1:0] carry_r, carry_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [NUM_BUFFERS-1:0] vld_r, vld_nxt;

  logic tag_we, cnt_we, ord_we;
  logic [SW-1:0] tag_waddr, tag_raddr, cnt_waddr, cnt_raddr, ord_waddr, ord_raddr;
  logic [TAG_W-1:0] tag_wdata, tag_rdata;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;
  logic [SW-1:0] ord_wdata, ord_rdata;

  logic in_xfer, in_slot_ok, resp_load;
  logic [SW-1:0] slot_idx;
  logic [CNT_W-1:0] cnt_inc, cnt_dec;

  // rams: tags, reference counts, recency order (entry 0 most recent)
  sbc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_BUFFERS)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(tag_raddr), .rdata(tag_rdata)
  );
  sbc_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BUFFERS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );
  sbc_ram #(.WIDTH(SW), .DEPTH(NUM_BUFFERS)) u_ord_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign in_xfer    = in_valid && in_ready;
  assign in_slot_ok = ({{(32-SLOT_W){1'b0}}, in_slot} < 32'(NUM_BUFFERS));
  assign slot_idx   = SW'(slot_r);
  assign resp_load  = (state_r == S_RESP) && (!out_valid_r || out_ready);
  assign cnt_inc    = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;
  assign cnt_dec    = cnt_rdata - 1'b1;

  assign out_valid         = out_valid_r;
  assign out_slot_out      = out_slot_r;
  assign out_status        = out_status_r;
  assign out_ref_count_out = out_cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: if (k_r == K_N - 1'b1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_GET) state_nxt = S_SCAN;
          else if (!in_slot_ok) state_nxt = S_RESP;
          else state_nxt = S_CNT_UPD;
        end
      end
      S_SCAN: if (k_r == K_LAST) state_nxt = S_GET_UPD;
      S_GET_UPD: state_nxt = S_RESP;
      S_CNT_UPD: begin
        if (op_r == OP_RELEASE && cnt_rdata == CNT_W'(1)) state_nxt = S_MRU;
        else state_nxt = S_RESP;
      end
      S_MRU: begin
        if (k_r != '0 && (ord_rdata == slot_idx || k_r == K_N)) state_nxt = S_RESP;
      end
      S_RESP: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  // datapath and ram control
  always_comb begin
    k_nxt = '0;
    op_nxt = op_r;
    dev_nxt = dev_r;
    sector_nxt = sector_r;
    slot_nxt = slot_r;
    s2_slot_nxt = ord_rdata;
    hit_nxt = hit_r;
    hit_slot_nxt = hit_slot_r;
    hit_cnt_nxt = hit_cnt_r;
    vic_nxt = vic_r;
    vic_slot_nxt = vic_slot_r;
    carry_nxt = carry_r;
    res_slot_nxt = res_slot_r;
    res_status_nxt = res_status_r;
    res_cnt_nxt = res_cnt_r;
    vld_nxt = vld_r;
    tag_we = 1'b0;
    tag_waddr = k_r[SW-1:0];
    tag_wdata = '1;
    tag_raddr = ord_rdata;
    cnt_we = 1'b0;
    cnt_waddr = k_r[SW-1:0];
    cnt_wdata = '0;
    cnt_raddr = ord_rdata;
    ord_we = 1'b0;
    ord_waddr = k_r[SW-1:0];
    ord_wdata = TOP_SLOT - k_r[SW-1:0];
    ord_raddr = k_r[SW-1:0];

    unique case (state_r)
      // clearing pass over all rams
      S_INIT: begin
        tag_we = 1'b1;
        cnt_we = 1'b1;
        ord_we = 1'b1;
        if (k_r != K_N - 1'b1) k_nxt = k_r + 1'b1;
      end
      // capture request, start count read for slot ops
      S_IDLE: begin
        cnt_raddr = SW'(in_slot);
        if (in_xfer) begin
          op_nxt = in_op;
          dev_nxt = in_dev;
          sector_nxt = in_sector;
          slot_nxt = in_slot;
          hit_nxt = 1'b0;
          vic_nxt = 1'b0;
          res_slot_nxt = in_slot;
          res_status_nxt = ST_VALID;
          res_cnt_nxt = '0;
        end
      end
      // recency walk: first tag match is the hit, last free slot the victim
      S_SCAN: begin
        k_nxt = k_r + 1'b1;
        if (k_r >= CW'(2)) begin
          if (!hit_r && tag_rdata == {dev_r, sector_r}) begin
            hit_nxt = 1'b1;
            hit_slot_nxt = s2_slot_r;
            hit_cnt_nxt = cnt_rdata;
          end
          if (cnt_rdata == '0) begin
            vic_nxt = 1'b1;
            vic_slot_nxt = s2_slot_r;
          end
        end
      end
      // apply hit or miss
      S_GET_UPD: begin
        if (hit_r) begin
          cnt_we = 1'b1;
          cnt_waddr = hit_slot_r;
          cnt_wdata = (hit_cnt_r == CNT_MAX) ? hit_cnt_r : hit_cnt_r + 1'b1;
          vld_nxt[hit_slot_r] = 1'b1;
          res_slot_nxt = SLOT_W'(hit_slot_r);
          res_status_nxt = vld_r[hit_slot_r] ? ST_VALID : ST_FILL;
          res_cnt_nxt = cnt_wdata;
        end else if (vic_r) begin
          tag_we = 1'b1;
          tag_waddr = vic_slot_r;
          tag_wdata = {dev_r, sector_r};
          cnt_we = 1'b1;
          cnt_waddr = vic_slot_r;
          cnt_wdata = CNT_W'(1);
          vld_nxt[vic_slot_r] = 1'b1;
          res_slot_nxt = SLOT_W'(vic_slot_r);
          res_status_nxt = ST_FILL;
          res_cnt_nxt = CNT_W'(1);
        end else begin
          res_slot_nxt = '0;
          res_status_nxt = ST_NOFREE;
          res_cnt_nxt = '0;
        end
      end
      // count read-modify-write for pin, unpin, release
      S_CNT_UPD: begin
        cnt_waddr = slot_idx;
        carry_nxt = slot_idx;
        if (op_r == OP_PIN) begin
          cnt_we = 1'b1;
          cnt_wdata = cnt_inc;
          res_cnt_nxt = cnt_inc;
        end else if (cnt_rdata == '0) begin
          res_status_nxt = ST_UNDERFLOW;
          res_cnt_nxt = '0;
        end else begin
          cnt_we = 1'b1;
          cnt_wdata = cnt_dec;
          res_cnt_nxt = cnt_dec;
        end
      end
      // shift recency entries down until the released slot is passed
      S_MRU: begin
        k_nxt = k_r + 1'b1;
        if (k_r != '0) begin
          ord_we = 1'b1;
          ord_waddr = SW'(k_r - 1'b1);
          ord_wdata = carry_r;
          carry_nxt = ord_rdata;
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_comb begin
    out_slot_nxt = out_slot_r;
    out_status_nxt = out_status_r;
    out_cnt_nxt = out_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (resp_load) begin
      out_valid_nxt = 1'b1;
      out_slot_nxt = res_slot_r;
      out_status_nxt = res_status_r;
      out_cnt_nxt = res_cnt_r;
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      k_r <= '0;
      out_valid_r <= 1'b0;
      vld_r <= '0;
      hit_r <= 1'b0;
      vic_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r <= vld_nxt;
      hit_r <= hit_nxt;
      vic_r <= vic_nxt;
    end
    op_r <= op_nxt;
    dev_r <= dev_nxt;
    sector_r <= sector_nxt;
    slot_r <= slot_nxt;
    s2_slot_r <= s2_slot_nxt;
    hit_slot_r <= hit_slot_nxt;
    hit_cnt_r <= hit_cnt_nxt;
    vic_slot_r <= vic_slot_nxt;
    carry_r <= carry_nxt;
    res_slot_r <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    res_cnt_r <= res_cnt_nxt;
    out_slot_r <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

endmodule

### rtl/core/sbc_checker.sv
// port-level checker for the sector buffer cache, bound to the top level
`timescale 1ns / 1ps
module sbc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sbc_pkg::SLOT_W-1:0]    out_slot_out,
  input logic [sbc_pkg::STATUS_W-1:0]  out_status,
  input logic [sbc_pkg::CNT_W-1:0]     out_ref_count_out
);
  import sbc_pkg::*;

  // a stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot_out))
    else $error("response changed while stalled");

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // no free buffer reports slot zero and count zero
  a_nofree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOFREE |-> out_slot_out == '0 && out_ref_count_out == '0)
    else $error("no-free response carries data");

  // a fill grant always holds a reference, an underflow reports count zero
  a_fill_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FILL || out_status == ST_UNDERFLOW) |->
      (out_status == ST_FILL) == (out_ref_count_out != '0))
    else $error("fill or underflow count wrong");

endmodule

bind sector_buffer_cache_lru_core sbc_checker u_sbc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_slot_out(out_slot_out),
  .out_status(out_status), .out_ref_count_out(out_ref_count_out)
);
